FILE: design/tet_element_matrices_top_defines.svh
// assertion macros shared by the tetrahedron element matrix block
`ifndef TET_ELEMENT_MATRICES_TOP_DEFINES_SVH
`define TET_ELEMENT_MATRICES_TOP_DEFINES_SVH

// same-cycle implication
`define TEM_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("tem check failed");

// next-cycle implication
`define TEM_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("tem check failed");

`endif

FILE: design/tem_pkg.sv
// widths and constants of the tetrahedron element matrix block
`default_nettype none
package tem_pkg;
  localparam int QBITS      = 50;
  localparam int K_W        = 48;
  localparam int M_W        = 47;
  localparam int NUM_W      = 148;
  localparam int DEN_W      = 105;
  localparam int DET_W      = 102;
  localparam int ARITH_DEPTH = 7;
  localparam int PIPE_DEPTH = ARITH_DEPTH + QBITS + 2;
  // mass path: divide by 15 through a reciprocal, exact below 2^MY_W
  localparam int MY_W       = 51;
  localparam int RECIP_W    = 52;
  localparam int RECIP_SH   = 55;
  localparam int MP_W       = MY_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP15 = RECIP_W'((64'd1 << RECIP_SH) / 64'd15 + 64'd1);
  localparam int MASS_STAGES = PIPE_DEPTH - ARITH_DEPTH - 3;
  typedef logic signed [32:0] diff_t;
  typedef logic signed [65:0] prod_t;
  typedef logic signed [66:0] adj_t;
  typedef logic signed [68:0] grad_t;
endpackage
`default_nettype wire

FILE: design/tem_div.sv
// pipelined restoring divider with round half away and saturation to 48 bits
`default_nettype none
module tem_div #(
  parameter int NUM_W = 148,
  parameter int DEN_W = 105
) (
  input  wire                          clk,
  input  wire                          en,
  input  wire logic signed [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0]        den,
  input  wire                          neg_ok,
  input  wire                          zero,
  output logic [tem_pkg::K_W-1:0]      res
);
  import tem_pkg::*;

  localparam int RW = NUM_W + 1;
  localparam int CW = (RW > DEN_W + QBITS) ? RW : DEN_W + QBITS;

  logic [CW-1:0]    rem [0:QBITS-1];
  logic [DEN_W-1:0] dn  [0:QBITS-1];
  logic [QBITS-1:0] q   [1:QBITS];
  logic             sg  [0:QBITS];
  logic             ovf [0:QBITS];
  logic             zr  [0:QBITS];
  logic             nok [0:QBITS];

  logic [NUM_W-1:0] mag;
  logic [RW-1:0]    n2;

  assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign n2  = {mag, 1'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= CW'(n2);
      dn[0]  <= den;
      sg[0]  <= num[NUM_W-1];
      ovf[0] <= CW'(n2) >= (CW'(den) << QBITS);
      zr[0]  <= zero;
      nok[0] <= neg_ok;
    end
  end

  for (genvar k = 1; k <= QBITS; k++) begin : g_stage
    logic [CW-1:0] sub;
    logic          ge;
    assign sub = CW'(dn[k-1]) << (QBITS - k);
    assign ge  = rem[k-1] >= sub;
    always_ff @(posedge clk) begin
      if (en) begin
        sg[k]  <= sg[k-1];
        ovf[k] <= ovf[k-1];
        zr[k]  <= zr[k-1];
        nok[k] <= nok[k-1];
      end
    end
    if (k == 1) begin : g_first
      always_ff @(posedge clk) begin
        if (en) q[k] <= QBITS'(ge);
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) q[k] <= {q[k-1][QBITS-2:0], ge};
      end
    end
    if (k < QBITS) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= ge ? rem[k-1] - sub : rem[k-1];
          dn[k]  <= dn[k-1];
        end
      end
    end
  end

  logic [QBITS:0]   qinc;
  logic [QBITS-1:0] qr;
  logic [QBITS-1:0] lim;
  logic             sat;
  logic [K_W-1:0]   mg;

  assign qinc = {1'b0, q[QBITS]} + (QBITS+1)'(1);
  assign qr   = qinc[QBITS:1];
  assign lim  = (sg[QBITS] && nok[QBITS]) ? (QBITS'(1) << (K_W - 1))
                                          : (QBITS'(1) << (K_W - 1)) - QBITS'(1);
  assign sat  = ovf[QBITS] || (qr > lim);
  assign mg   = sat ? lim[K_W-1:0] : qr[K_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      if (zr[QBITS]) res <= '0;
      else if (sg[QBITS]) res <= K_W'(-mg);
      else res <= mg;
    end
  end
endmodule
`default_nettype wire

FILE: design/tet_element_matrices_top.sv
// top level of the tetrahedron stiffness and mass element matrix block
// Usage: one tetrahedron per transaction on the s_axis side (four corners,
// signed Q16.16), one result per transaction on the m_axis side: ten distinct
// stiffness entries (signed Q24.24, saturated) and the two mass values.
// The pipeline takes a new element every cycle unless the receiver holds a
// result waiting, so the sustained rate is one element per clock. It has
// seven arithmetic stages (edge vectors, adjugate products, adjugate, split
// products, products, sums, numerators) and a 52 stage divider, one quotient
// bit per stage, that sets the depth.
// The last divider stage is the output register. When the receiver holds
// m_axis_tready low with a result waiting, the whole pipeline freezes and
// s_axis_tready drops; nothing is lost or repeated, and empty stages do not
// stall anything while the output is free.
// A degenerate element (zero determinant) gives all zero fields.
// Reset (rst, synchronous) clears all valid bits; data registers keep garbage
// that is never shown.
`default_nettype none
`include "tet_element_matrices_top_defines.svh"
module tet_element_matrices_top (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // p0_x p0_y p0_z p1_x p1_y p1_z p2_x p2_y p2_z p3_x p3_y p3_z, 32 bits each
  input  wire [383:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // k_00 k_01 k_02 k_03 k_11 k_12 k_13 k_22 k_23 k_33 (48 each),
  // mass_off mass_diag (47 each), 2 zero bits
  output logic [575:0] m_axis_tdata
);
  import tem_pkg::*;

  localparam int PI [10] = '{0, 0, 0, 0, 1, 1, 1, 2, 2, 3};
  localparam int PJ [10] = '{0, 1, 2, 3, 1, 2, 3, 2, 3, 3};

  logic                  en;
  logic [PIPE_DEPTH-1:0] vld;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], s_axis_tvalid};
    end
  end

  // edge vectors
  diff_t m1 [3][3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          m1[r][c] <= 33'(signed'(s_axis_tdata[32*((c+1)*3+r) +: 32]))
                    - 33'(signed'(s_axis_tdata[32*r +: 32]));
        end
      end
    end
  end

  // adjugate products
  prod_t pa [9];
  prod_t pb [9];
  diff_t r2 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      pa[0] <= m1[1][1] * m1[2][2];  pb[0] <= m1[1][2] * m1[2][1];
      pa[1] <= m1[0][2] * m1[2][1];  pb[1] <= m1[0][1] * m1[2][2];
      pa[2] <= m1[0][1] * m1[1][2];  pb[2] <= m1[0][2] * m1[1][1];
      pa[3] <= m1[1][2] * m1[2][0];  pb[3] <= m1[1][0] * m1[2][2];
      pa[4] <= m1[0][0] * m1[2][2];  pb[4] <= m1[0][2] * m1[2][0];
      pa[5] <= m1[0][2] * m1[1][0];  pb[5] <= m1[0][0] * m1[1][2];
      pa[6] <= m1[1][0] * m1[2][1];  pb[6] <= m1[1][1] * m1[2][0];
      pa[7] <= m1[0][1] * m1[2][0];  pb[7] <= m1[0][0] * m1[2][1];
      pa[8] <= m1[0][0] * m1[1][1];  pb[8] <= m1[0][1] * m1[1][0];
      for (int c = 0; c < 3; c++) r2[c] <= m1[0][c];
    end
  end

  // adjugate rows
  adj_t  g3 [3][3];
  diff_t r3 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 9; a++) g3[a/3][a%3] <= 67'(pa[a]) - 67'(pb[a]);
      for (int c = 0; c < 3; c++) r3[c] <= r2[c];
    end
  end

  // gradient rows and determinant partial products
  grad_t                g4 [4][3];
  logic signed [67:0]   dl [3];
  logic signed [65:0]   dh [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        g4[0][c] <= -(69'(g3[0][c]) + 69'(g3[1][c]) + 69'(g3[2][c]));
        for (int i = 1; i < 4; i++) g4[i][c] <= 69'(g3[i-1][c]);
        dl[c] <= r3[c] * $signed({1'b0, g3[c][0][33:0]});
        dh[c] <= r3[c] * $signed(g3[c][0][66:34]);
      end
    end
  end

  // determinant and dot product partials
  logic signed [DET_W-1:0] det5;
  always_ff @(posedge clk) begin
    if (en) begin
      det5 <= (DET_W'(dh[0]) <<< 34) + DET_W'(dl[0])
            + (DET_W'(dh[1]) <<< 34) + DET_W'(dl[1])
            + (DET_W'(dh[2]) <<< 34) + DET_W'(dl[2]);
    end
  end

  logic signed [71:0]      pll  [10][3];
  logic signed [69:0]      plh  [10][3];
  logic signed [69:0]      phl  [10][3];
  logic signed [67:0]      phh  [10][3];
  logic signed [137:0]     prd  [10][3];
  logic signed [NUM_W-1:0] num7 [10];
  logic [K_W-1:0]          kres [10];

  logic [DET_W-1:0] dabs6;
  logic             zr6;
  logic [DET_W-1:0] dabs7;
  logic [DEN_W-1:0] den7;
  logic             zr7;

  always_ff @(posedge clk) begin
    if (en) begin
      dabs6 <= det5[DET_W-1] ? DET_W'(-det5) : DET_W'(det5);
      zr6   <= det5 == '0;
      dabs7 <= dabs6;
      den7  <= (DEN_W'(dabs6) << 2) + (DEN_W'(dabs6) << 1);
      zr7   <= zr6;
    end
  end

  for (genvar n = 0; n < 10; n++) begin : g_pair
    for (genvar k = 0; k < 3; k++) begin : g_axis
      always_ff @(posedge clk) begin
        if (en) begin
          pll[n][k] <= $signed({1'b0, g4[PI[n]][k][34:0]})
                     * $signed({1'b0, g4[PJ[n]][k][34:0]});
          plh[n][k] <= $signed({1'b0, g4[PI[n]][k][34:0]})
                     * $signed(g4[PJ[n]][k][68:35]);
          phl[n][k] <= $signed(g4[PI[n]][k][68:35])
                     * $signed({1'b0, g4[PJ[n]][k][34:0]});
          phh[n][k] <= $signed(g4[PI[n]][k][68:35])
                     * $signed(g4[PJ[n]][k][68:35]);
          prd[n][k] <= (138'(phh[n][k]) <<< 70)
                     + ((138'(plh[n][k]) + 138'(phl[n][k])) <<< 35)
                     + 138'(pll[n][k]);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        num7[n] <= (NUM_W'(prd[n][0]) + NUM_W'(prd[n][1]) + NUM_W'(prd[n][2])) <<< 8;
      end
    end
    tem_div #(
      .NUM_W(NUM_W),
      .DEN_W(DEN_W)
    ) u_kdiv (
      .clk   (clk),
      .en    (en),
      .num   (num7[n]),
      .den   (den7),
      .neg_ok(1'b1),
      .zero  (zr7),
      .res   (kres[n])
    );
    assign m_axis_tdata[K_W*n +: K_W] = kres[n];
  end

  // mass values: round(x / 120) and round(x / 60) with x = |det| >> 24,
  // done as a shift and a reciprocal multiply by 1/15
  logic [DET_W-24:0]     xoff;
  logic [DET_W-24:0]     xdiag;
  logic [MY_W-1:0]       my8  [2];
  logic                  mo8  [2];
  logic [51:0]           mll  [2];
  logic [51:0]           mlh  [2];
  logic [50:0]           mhl  [2];
  logic [50:0]           mhh  [2];
  logic                  mo9  [2];
  logic [K_W-1:0]        mq10 [2];
  logic                  mo10 [2];
  logic [2*M_W-1:0]      mdly [MASS_STAGES];

  assign xoff  = (DET_W-23)'(dabs7[DET_W-1:24]) + (DET_W-23)'(60);
  assign xdiag = (DET_W-23)'(dabs7[DET_W-1:24]) + (DET_W-23)'(30);

  always_ff @(posedge clk) begin
    if (en) begin
      my8[0] <= xoff[MY_W+2:3];
      mo8[0] <= |xoff[DET_W-24:MY_W+3];
      my8[1] <= xdiag[MY_W+1:2];
      mo8[1] <= |xdiag[DET_W-24:MY_W+2];
      for (int i = 0; i < 2; i++) begin
        mll[i]  <= my8[i][25:0] * RECIP15[25:0];
        mlh[i]  <= my8[i][25:0] * RECIP15[51:26];
        mhl[i]  <= my8[i][50:26] * RECIP15[25:0];
        mhh[i]  <= my8[i][50:26] * RECIP15[51:26];
        mo9[i]  <= mo8[i];
        mq10[i] <= K_W'(((MP_W'(mhh[i]) << 52) + ((MP_W'(mlh[i]) + MP_W'(mhl[i])) << 26)
                   + MP_W'(mll[i])) >> RECIP_SH);
        mo10[i] <= mo9[i];
      end
      mdly[0] <= {(mo10[1] || mq10[1][K_W-1]) ? {M_W{1'b1}} : mq10[1][M_W-1:0],
                  (mo10[0] || mq10[0][K_W-1]) ? {M_W{1'b1}} : mq10[0][M_W-1:0]};
      for (int i = 1; i < MASS_STAGES; i++) mdly[i] <= mdly[i-1];
    end
  end

  assign m_axis_tdata[480 +: M_W]     = mdly[MASS_STAGES-1][M_W-1:0];
  assign m_axis_tdata[480+M_W +: M_W] = mdly[MASS_STAGES-1][2*M_W-1:M_W];
  assign m_axis_tdata[575:574]        = '0;

  `TEM_ASSERT_NXT(a_accept_enters, clk, rst, s_axis_tvalid && s_axis_tready, vld[0])
  `TEM_ASSERT_IMP(a_diag_nonneg, clk, rst, m_axis_tvalid, !m_axis_tdata[47] && !m_axis_tdata[239] && !m_axis_tdata[383] && !m_axis_tdata[479])
  `TEM_ASSERT_IMP(a_mass_order, clk, rst, m_axis_tvalid && (m_axis_tdata[573:527] == '0), m_axis_tdata[526:480] == '0)
endmodule
`default_nettype wire

FILE: verif/tet_element_matrices_top_test.sv
// self-checking testbench for the tetrahedron stiffness and mass element matrix block
`default_nettype none
module tet_element_matrices_top_test;
  import tem_pkg::*;

  typedef logic signed [255:0] wide_t;

  localparam int NUM_ITEMS = 1900;

  class element_scoreboard;
    logic [575:0] pending[$];
    int errors = 0;

    static function wide_t round_div(wide_t num, wide_t den, wide_t plim, wide_t nlim);
      logic neg;
      wide_t mag, q, r, lim;
      neg = num < 0;
      mag = neg ? -num : num;
      q = mag / den;
      r = mag % den;
      if (2 * r >= den) q = q + 1;
      lim = neg ? nlim : plim;
      if (q > lim) q = lim;
      return neg ? -q : q;
    endfunction

    static function logic [575:0] element_matrices(logic [383:0] d);
      wide_t e[3][3];
      wide_t g[4][3];
      wide_t det, den, s, v, kmax;
      logic [575:0] res;
      int n;
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          e[r][c] = wide_t'($signed(d[((c + 1) * 3 + r) * 32 +: 32])) -
                    wide_t'($signed(d[r * 32 +: 32]));
      g[1][0] = e[1][1] * e[2][2] - e[1][2] * e[2][1];
      g[1][1] = e[0][2] * e[2][1] - e[0][1] * e[2][2];
      g[1][2] = e[0][1] * e[1][2] - e[0][2] * e[1][1];
      g[2][0] = e[1][2] * e[2][0] - e[1][0] * e[2][2];
      g[2][1] = e[0][0] * e[2][2] - e[0][2] * e[2][0];
      g[2][2] = e[0][2] * e[1][0] - e[0][0] * e[1][2];
      g[3][0] = e[1][0] * e[2][1] - e[1][1] * e[2][0];
      g[3][1] = e[0][1] * e[2][0] - e[0][0] * e[2][1];
      g[3][2] = e[0][0] * e[1][1] - e[0][1] * e[1][0];
      for (int c = 0; c < 3; c++) g[0][c] = -(g[1][c] + g[2][c] + g[3][c]);
      det = e[0][0] * g[1][0] + e[0][1] * g[2][0] + e[0][2] * g[3][0];
      res = '0;
      if (det == 0) return res;
      if (det < 0) det = -det;
      den = det * 6;
      kmax = (wide_t'(1) <<< 47) - 1;
      n = 0;
      for (int i = 0; i < 4; i++)
        for (int j = i; j < 4; j++) begin
          s = 0;
          for (int k = 0; k < 3; k++) s = s + g[i][k] * g[j][k];
          v = round_div(s * 256, den, kmax, kmax + 1);
          res[n * 48 +: 48] = v[47:0];
          n++;
        end
      v = round_div(det, wide_t'(120) <<< 24, kmax, kmax);
      res[480 +: 47] = v[46:0];
      v = round_div(det, wide_t'(60) <<< 24, kmax, kmax);
      res[527 +: 47] = v[46:0];
      return res;
    endfunction

    function void note_element(logic [383:0] d);
      pending.push_back(element_matrices(d));
    endfunction

    function void check_result(logic [575:0] got);
      logic [575:0] want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      for (int f = 0; f < 10; f++)
        if (got[f * 48 +: 48] !== want[f * 48 +: 48]) begin
          $display("%0t: stiffness entry %0d expected %h actual %h", $time, f,
                   want[f * 48 +: 48], got[f * 48 +: 48]);
          errors++;
        end
      if (got[480 +: 47] !== want[480 +: 47]) begin
        $display("%0t: mass_off expected %h actual %h", $time, want[480 +: 47], got[480 +: 47]);
        errors++;
      end
      if (got[527 +: 47] !== want[527 +: 47]) begin
        $display("%0t: mass_diag expected %h actual %h", $time, want[527 +: 47],
                 got[527 +: 47]);
        errors++;
      end
      if (got[575:574] !== 2'b00) begin
        $display("%0t: pad bits expected 0 actual %b", $time, got[575:574]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [383:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [575:0] m_axis_tdata;

  element_scoreboard sb = new();
  logic no_idle = 0;
  logic stim_done = 0;

  tet_element_matrices_top dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #4 clk = ~clk;

  function automatic logic [383:0] tet_from(int c[12]);
    logic [383:0] d;
    for (int i = 0; i < 12; i++) d[i * 32 +: 32] = c[i];
    return d;
  endfunction

  function automatic logic [383:0] random_tet();
    int c[12];
    int mode, sh;
    mode = $urandom_range(99);
    if (mode < 12) begin
      for (int i = 0; i < 12; i++) c[i] = $urandom;
    end else begin
      sh = $urandom_range(28);
      for (int i = 0; i < 3; i++) c[i] = $urandom;
      for (int i = 3; i < 12; i++) c[i] = c[i % 3] + ($signed($urandom) >>> sh);
      if (mode < 20) begin
        for (int i = 0; i < 3; i++) c[9 + i] = c[3 * $urandom_range(2) + i];
      end else if (mode < 26) begin
        for (int i = 1; i < 4; i++) c[i * 3 + 2] = c[2];
      end
    end
    return tet_from(c);
  endfunction

  task automatic send_element(logic [383:0] d);
    if (!no_idle && $urandom_range(99) < 38) begin
      s_axis_tvalid <= 0;
      do @(posedge clk); while ($urandom_range(99) < 38);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= d;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_element(d);
  endtask

  initial begin
    int max_i, min_i;
    max_i = 32'h7fffffff;
    min_i = 32'h80000000;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // all corners coincident, unit tet, mirrored, flat, tiny and huge
    send_element(tet_from('{0,0,0, 0,0,0, 0,0,0, 0,0,0}));
    send_element(tet_from('{0,0,0, 65536,0,0, 0,65536,0, 0,0,65536}));
    send_element(tet_from('{0,0,0, 0,65536,0, 65536,0,0, 0,0,65536}));
    send_element(tet_from('{0,0,0, 65536,0,0, 0,65536,0, 65536,65536,0}));
    send_element(tet_from('{0,0,0, 1,0,0, 0,1,0, 0,0,1}));
    send_element(tet_from('{min_i,min_i,min_i, max_i,min_i,min_i, min_i,max_i,min_i,
                            min_i,min_i,max_i}));
    send_element(tet_from('{max_i,max_i,max_i, min_i,max_i,max_i, max_i,min_i,max_i,
                            max_i,max_i,min_i}));
    send_element(tet_from('{max_i,max_i,max_i, max_i,max_i,max_i, min_i,min_i,min_i,
                            min_i,0,max_i}));
    send_element(tet_from('{-1,-1,-1, -1,-1,-1, -1,-1,-1, -1,-1,-1}));
    send_element(tet_from('{0,0,0, 65536*200,0,0, 0,65536*200,0, 0,0,65536*200}));
    send_element(tet_from('{65536,0,0, 0,65536,0, 0,0,65536, 0,0,0}));
    send_element(tet_from('{0,0,0, 100,0,0, 0,100,0, 30,30,7}));
    send_element(tet_from('{min_i,0,max_i, 0,max_i,min_i, max_i,min_i,0, 0,0,0}));
    send_element(tet_from('{0,0,0, 65536,65536,0, 131072,131072,0, 0,0,65536}));
    for (int n = 0; n < NUM_ITEMS; n++) begin
      no_idle <= (n >= 700 && n < 1000);
      send_element(random_tet());
    end
    s_axis_tvalid <= 0;
    stim_done <= 1;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      m_axis_tready <= rst ? 1'b0 : (no_idle || $urandom_range(99) >= 38);
    end
  end

  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (sb.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #(8 * 400000);
    $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire
